### sv/twss_pkg.sv
// Shared types and codes for the time-weighted SNR statistics block.
// No dependencies; every other file but twss_fifo imports this package.
package twss_pkg;

  localparam int FIELD_BITS = 32;
  localparam int SUM_BITS   = 64;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Decoded command handed from front to back
  typedef enum logic [1:0] {
    CMD_START,
    CMD_SAMPLE,
    CMD_QUERY,
    CMD_NOP
  } cmd_t;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [FIELD_BITS-1:0] now_time;
    logic [FIELD_BITS-1:0] snr_value;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] min_snr;
    logic [FIELD_BITS-1:0] max_snr;
    logic [FIELD_BITS-1:0] mean_snr;
  } out_item_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [FIELD_BITS-1:0] now;
    logic [FIELD_BITS-1:0] snr;
  } cmd_item_t;

endpackage

### sv/twss_fifo.sv
// Two-entry queue used between front and back and on the result side.
// Depends on nothing but its WIDTH parameter.
module twss_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("fifo fill level out of range");

endmodule

### sv/twss_front.sv
// Front end: accepts input transactions, decodes the request and masks fields.
// Depends on twss_pkg and twss_fifo.
module twss_front import twss_pkg::*; #(
  parameter int SNR_BITS  = 32,
  parameter int TIME_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_data,
  output logic      in_full,
  input  logic      cmd_pop,
  output cmd_item_t cmd_item,
  output logic      cmd_empty
);

  localparam logic [FIELD_BITS-1:0] SNR_MASK  =
    FIELD_BITS'((64'd1 << SNR_BITS) - 64'd1);
  localparam logic [FIELD_BITS-1:0] TIME_MASK =
    FIELD_BITS'((64'd1 << TIME_BITS) - 64'd1);

  cmd_item_t enq_item;
  logic [$bits(cmd_item_t)-1:0] deq_bits;

  // Decode request kind and drop unused upper bits
  always_comb begin
    enq_item.now = in_data.now_time & TIME_MASK;
    enq_item.snr = in_data.snr_value & SNR_MASK;
    unique case (in_data.req_type)
      REQ_START:  enq_item.cmd = CMD_START;
      REQ_SAMPLE: enq_item.cmd = CMD_SAMPLE;
      REQ_QUERY:  enq_item.cmd = CMD_QUERY;
      default:    enq_item.cmd = CMD_NOP;
    endcase
  end

  twss_fifo #(.WIDTH($bits(cmd_item_t))) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (enq_item),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (deq_bits),
    .empty (cmd_empty)
  );

  assign cmd_item = cmd_item_t'(deq_bits);

endmodule

### sv/twss_div.sv
// Bit-serial restoring divider: 64-bit sum over a D_BITS span,
// quotient saturated to Q_BITS. Depends on twss_pkg.
module twss_div import twss_pkg::*; #(
  parameter int Q_BITS = 32,
  parameter int D_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SUM_BITS-1:0] dividend,
  input  logic [D_BITS-1:0]   divisor,
  output logic                done,
  output logic [Q_BITS-1:0]   quotient
);

  localparam int HI_BITS = SUM_BITS - Q_BITS;
  localparam int CNT_W   = $clog2(Q_BITS + 1);

  logic [D_BITS-1:0]  rem_r;
  logic [D_BITS-1:0]  div_r;
  logic [Q_BITS-1:0]  quo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [HI_BITS-1:0] hi;
  logic               sat;
  logic [D_BITS:0]    shifted;
  logic [D_BITS:0]    diff;
  logic               ge;

  // Quotient overflows Q_BITS exactly when the upper part reaches the divisor
  assign hi  = dividend[SUM_BITS-1:Q_BITS];
  assign sat = (hi >= HI_BITS'(divisor));

  // One quotient bit per cycle
  assign shifted = {rem_r, quo_r[Q_BITS-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign ge      = (shifted >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      div_r  <= '0;
      quo_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        div_r <= divisor;
        if (sat) begin
          quo_r  <= '1;
          done_r <= 1'b1;
        end else begin
          rem_r  <= hi[D_BITS-1:0];
          quo_r  <= dividend[Q_BITS-1:0];
          cnt_r  <= CNT_W'(Q_BITS);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? diff[D_BITS-1:0] : shifted[D_BITS-1:0];
        quo_r <= {quo_r[Q_BITS-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < div_r))
    else $error("partial remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (!busy_r && !done_r))
    else $error("divider restarted while in use");

endmodule

### sv/twss_back.sv
// Back end: holds the statistics, folds intervals and drives the divider.
// Depends on twss_pkg and twss_div.
module twss_back import twss_pkg::*; #(
  parameter int SNR_BITS  = 32,
  parameter int TIME_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_item_t cmd_item,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  output out_item_t res_item,
  output logic      res_push,
  input  logic      res_full
);

  localparam int PROD_BITS = SNR_BITS + TIME_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_CHK,
    S_DIV,
    S_OUT
  } state_t;

  state_t                 state_r;
  logic [SNR_BITS-1:0]    min_r;
  logic [SNR_BITS-1:0]    max_r;
  logic [SNR_BITS-1:0]    mean_r;
  logic [SNR_BITS-1:0]    last_r;
  logic [TIME_BITS-1:0]   start_tick_r;
  logic [TIME_BITS-1:0]   last_tick_r;
  logic [SUM_BITS-1:0]    sum_r;
  logic [SNR_BITS-1:0]    next_level_r;
  logic [TIME_BITS-1:0]   now_r;
  logic [TIME_BITS-1:0]   elapsed_r;
  logic [TIME_BITS-1:0]   span_r;
  logic [PROD_BITS-1:0]   prod_r;
  logic [TIME_BITS-1:0]   cmd_now;
  logic [SNR_BITS-1:0]    cmd_snr;
  logic [SUM_BITS:0]      total;
  logic                   div_start;
  logic                   div_done;
  logic [SNR_BITS-1:0]    div_quo;

  assign cmd_now = cmd_item.now[TIME_BITS-1:0];
  assign cmd_snr = cmd_item.snr[SNR_BITS-1:0];
  assign cmd_pop = (state_r == S_IDLE) && !cmd_empty;
  assign total   = {1'b0, sum_r} + (SUM_BITS + 1)'(prod_r);

  assign div_start = (state_r == S_CHK) && (span_r != '0);
  assign res_push  = (state_r == S_OUT) && !res_full;

  assign res_item.min_snr  = FIELD_BITS'(min_r);
  assign res_item.max_snr  = FIELD_BITS'(max_r);
  assign res_item.mean_snr = FIELD_BITS'(mean_r);

  twss_div #(.Q_BITS(SNR_BITS), .D_BITS(TIME_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (span_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      min_r        <= '0;
      max_r        <= '0;
      mean_r       <= '0;
      last_r       <= '0;
      start_tick_r <= '0;
      last_tick_r  <= '0;
      sum_r        <= '0;
      next_level_r <= '0;
      now_r        <= '0;
      elapsed_r    <= '0;
      span_r       <= '0;
      prod_r       <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          // Take one command and decide whether an interval closes
          if (!cmd_empty) begin
            now_r     <= cmd_now;
            elapsed_r <= cmd_now - last_tick_r;
            span_r    <= cmd_now - start_tick_r;
            unique case (cmd_item.cmd)
              CMD_START: begin
                min_r        <= cmd_snr;
                max_r        <= cmd_snr;
                mean_r       <= cmd_snr;
                last_r       <= cmd_snr;
                start_tick_r <= cmd_now;
                last_tick_r  <= cmd_now;
                sum_r        <= '0;
                state_r      <= S_OUT;
              end
              CMD_SAMPLE: begin
                next_level_r <= cmd_snr;
                state_r      <= S_MUL;
              end
              CMD_QUERY: begin
                next_level_r <= last_r;
                state_r      <= (cmd_now != last_tick_r) ? S_MUL : S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_MUL: begin
          // Weight the closing level by its duration; fold into min/max
          prod_r <= PROD_BITS'(last_r) * PROD_BITS'(elapsed_r);
          if (last_r > max_r) max_r <= last_r;
          if (last_r < min_r) min_r <= last_r;
          state_r <= S_ADD;
        end
        S_ADD: begin
          // Saturating accumulate
          sum_r   <= total[SUM_BITS] ? '1 : total[SUM_BITS-1:0];
          state_r <= S_CHK;
        end
        S_CHK: begin
          // Zero span keeps the old mean
          last_r      <= next_level_r;
          last_tick_r <= now_r;
          state_r     <= (span_r != '0) ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            mean_r  <= div_quo;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_full) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    min_r <= max_r)
    else $error("minimum above maximum");

  a_div_follow: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == S_DIV))
    else $error("divider started outside the divide sequence");

endmodule

### sv/time_weighted_snr_stats.sv
// Top level of the time-weighted SNR statistics block.
// Depends on twss_pkg, twss_front, twss_back and twss_fifo.
//
// Each input transaction (start, sample or query) yields exactly one result
// with min, max and time-weighted mean SNR. A two-entry command queue in front
// and a two-entry result queue behind let both sides run on their own. Start
// requests, unused codes and queries at an unchanged time go from the idle
// state straight to the output state in the back end. A sample, or a query
// after time advanced, passes through multiply, saturating add and a check
// of the span, then a bit-serial divider that retires one mean bit per cycle;
// a saturated mean skips the bit-serial steps and a zero span since start
// skips the divide. Items are processed one at a time in arrival order.
module time_weighted_snr_stats import twss_pkg::*; #(
  parameter int SNR_BITS  = 32,
  parameter int TIME_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_data,
  output logic      in_full,
  input  logic      out_pop,
  output out_item_t out_data,
  output logic      out_empty
);

  cmd_item_t cmd_item;
  logic      cmd_empty;
  logic      cmd_pop;
  out_item_t res_item;
  logic      res_push;
  logic      res_full;
  logic [$bits(out_item_t)-1:0] res_bits;

  twss_front #(.SNR_BITS(SNR_BITS), .TIME_BITS(TIME_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cmd_pop   (cmd_pop),
    .cmd_item  (cmd_item),
    .cmd_empty (cmd_empty)
  );

  twss_back #(.SNR_BITS(SNR_BITS), .TIME_BITS(TIME_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_item  (cmd_item),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_item  (res_item),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  // Result queue
  twss_fifo #(.WIDTH($bits(out_item_t))) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_item),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_bits),
    .empty (out_empty)
  );

  assign out_data = out_item_t'(res_bits);

endmodule
